### sv/mp2_pkg.sv
// ----------------------------------------------------------------------------
// mp2_pkg
// shared widths, register codes and word types of the 2x2 max-pool core
// ----------------------------------------------------------------------------
package mp2_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int POS_W        = 2;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CHAN_REG_W   = 11;
  localparam int ROW_W        = 12;
  localparam int CHAN_W       = 10;
  localparam int MAX_HEIGHT   = 4096;
  localparam int MAX_CHANNELS = 1024;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd32;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd32;
  localparam logic [CHAN_REG_W-1:0]   CHAN_RESET   = 11'd3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } mp2_cfg_idx_e;

  // window position codes
  localparam logic [POS_W-1:0] POS_TL = 2'd0;
  localparam logic [POS_W-1:0] POS_TR = 2'd1;
  localparam logic [POS_W-1:0] POS_BL = 2'd2;
  localparam logic [POS_W-1:0] POS_BR = 2'd3;

  typedef struct packed {
    logic [WIDTH_REG_W-1:0]  image_width;
    logic [HEIGHT_REG_W-1:0] image_height;
    logic [CHAN_REG_W-1:0]   channel_count;
  } mp2_cfg_t;

  // line store entry: top-row pair maximum
  typedef struct packed {
    logic                right;
    logic [SAMPLE_W-1:0] value;
  } mp2_pair_t;

  // bottom-right word handed from the scan stage to the merge stage
  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] bottom_left;
    logic [SAMPLE_W-1:0] bottom_right;
    logic                last;
  } mp2_issue_t;

endpackage

### sv/mp2_sample_if.sv
// ----------------------------------------------------------------------------
// mp2_sample_if
// input sample channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface mp2_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [mp2_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

### sv/mp2_result_if.sv
// ----------------------------------------------------------------------------
// mp2_result_if
// pooled result channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface mp2_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [mp2_pkg::SAMPLE_W-1:0] pooled_value;
  logic [mp2_pkg::POS_W-1:0]           max_position;
  logic                                last_of_frame;

  modport source (output valid, output pooled_value, output max_position,
                  output last_of_frame, input ready);
  modport sink (input valid, input pooled_value, input max_position,
                input last_of_frame, output ready);
endinterface

### sv/mp2_cfg_if.sv
// ----------------------------------------------------------------------------
// mp2_cfg_if
// register write channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface mp2_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mp2_pkg::CFG_IDX_W-1:0]     index;
  logic [mp2_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### sv/max_pool_2x2_stream_core.sv
// ----------------------------------------------------------------------------
// max_pool_2x2_stream_core
// 2x2 stride-2 max pooling over a channel-major raster sample stream
// ----------------------------------------------------------------------------
//
//   channel   dir  word                                        handshake
//   sample_i  in   sample (q8.8)                               valid/ready
//   result_o  out  pooled_value, max_position, last_of_frame   valid/ready
//   cfg_i     in   index, data (register write)                valid/ready
//
// one sample word is taken per clock while sample_i is ready; the line
// store read issued at a bottom-right sample returns at the same edge
// that accepts it, and the merged word is then loaded into the output
// register as soon as result_o can take a new word
// reset clears counters and the pair register; the line store is not
// cleared since every entry is written in a top row before it is read
// sample_i stalls only while a bottom-right word waits in the merge stage
// and result_o holds a word that is not taken; cfg_i is always ready
//
module max_pool_2x2_stream_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  mp2_sample_if.sink     sample_i,
  mp2_result_if.source   result_o,
  mp2_cfg_if.sink        cfg_i
);

  // line store holds one pair maximum per two columns
  localparam int DEPTH  = MAX_WIDTH / 2;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mp2_pkg::mp2_cfg_t   cfg_q, cfg_d;
  logic                accept;
  logic                can_take;
  logic                wr_en, rd_en;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  mp2_pkg::mp2_pair_t  wr_data, rd_data;
  mp2_pkg::mp2_issue_t issue;

  // register writes, unknown indexes ignored
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        mp2_pkg::CFG_IMAGE_WIDTH:
          cfg_d.image_width = cfg_i.data[mp2_pkg::WIDTH_REG_W-1:0];
        mp2_pkg::CFG_IMAGE_HEIGHT:
          cfg_d.image_height = cfg_i.data[mp2_pkg::HEIGHT_REG_W-1:0];
        mp2_pkg::CFG_CHANNEL_COUNT:
          cfg_d.channel_count = cfg_i.data[mp2_pkg::CHAN_REG_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width   <= mp2_pkg::WIDTH_RESET;
      cfg_q.image_height  <= mp2_pkg::HEIGHT_RESET;
      cfg_q.channel_count <= mp2_pkg::CHAN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // input handshake
  assign sample_i.ready = can_take;
  assign accept         = sample_i.valid && can_take;

  // counters and top-row reduction
  mp2_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .ADDR_W    (ADDR_W)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .accept_i  (accept),
    .sample_i  (sample_i.sample),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .issue_o   (issue)
  );

  // top-row line store; a slot is written a full row before it is read,
  // so write and read never meet on the same entry in one cycle
  mp2_ram #(
    .WIDTH  ($bits(mp2_pkg::mp2_pair_t)),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // window merge and output register; the read data holds while stalled
  // because no new read is issued until the merge stage moves on
  mp2_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .issue_i    (issue),
    .top_i      (rd_data),
    .can_take_o (can_take),
    .result_o   (result_o)
  );

endmodule

### sv/mp2_ram.sv
// ----------------------------------------------------------------------------
// mp2_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mp2_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 512,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/mp2_scan.sv
// ----------------------------------------------------------------------------
// mp2_scan
// raster counters, top-row pair reduction and line store addressing
// ----------------------------------------------------------------------------
module mp2_scan #(
  parameter int MAX_WIDTH = 1024,
  parameter int COL_W = $clog2(MAX_WIDTH),
  parameter int ADDR_W = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mp2_pkg::mp2_cfg_t              cfg_i,
  input  logic                           accept_i,
  input  logic [mp2_pkg::SAMPLE_W-1:0]   sample_i,
  output logic                           wr_en_o,
  output logic [ADDR_W-1:0]              wr_addr_o,
  output mp2_pkg::mp2_pair_t             wr_data_o,
  output logic                           rd_en_o,
  output logic [ADDR_W-1:0]              rd_addr_o,
  output mp2_pkg::mp2_issue_t            issue_o
);

  // compare width for columns: covers both the register and MAX_WIDTH
  localparam int CW = (COL_W + 1 > mp2_pkg::WIDTH_REG_W) ? COL_W + 1 : mp2_pkg::WIDTH_REG_W;
  localparam int HW = mp2_pkg::HEIGHT_REG_W;
  localparam int NW = mp2_pkg::CHAN_REG_W;

  logic [COL_W-1:0]              col_q, col_d;
  logic [mp2_pkg::ROW_W-1:0]     row_q, row_d;
  logic [mp2_pkg::CHAN_W-1:0]    chn_q, chn_d;
  logic [mp2_pkg::SAMPLE_W-1:0]  pair_q, pair_d;

  logic [CW-1:0] w_raw, w_eff, w_even, col_cur, col_inc;
  logic [HW-1:0] h_raw, h_eff, h_even, row_cur, row_inc;
  logic [NW-1:0] c_raw, c_eff, chn_cur, chn_inc;
  logic          active, right, bottom, last;
  mp2_pkg::mp2_pair_t pair_best;

  // effective bounds
  always_comb begin
    w_raw = CW'(cfg_i.image_width);
    if (w_raw < CW'(2)) begin
      w_eff = CW'(2);
    end else if (w_raw > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    h_raw = cfg_i.image_height;
    if (h_raw < HW'(2)) begin
      h_eff = HW'(2);
    end else if (h_raw > HW'(mp2_pkg::MAX_HEIGHT)) begin
      h_eff = HW'(mp2_pkg::MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
    c_raw = cfg_i.channel_count;
    if (c_raw < NW'(1)) begin
      c_eff = NW'(1);
    end else if (c_raw > NW'(mp2_pkg::MAX_CHANNELS)) begin
      c_eff = NW'(mp2_pkg::MAX_CHANNELS);
    end else begin
      c_eff = c_raw;
    end
    w_even = {w_eff[CW-1:1], 1'b0};
    h_even = {h_eff[HW-1:1], 1'b0};
  end

  // current position, restarted if a bound shrank below it
  always_comb begin
    col_cur = (CW'(col_q) >= w_eff) ? '0 : CW'(col_q);
    row_cur = (HW'(row_q) >= h_eff) ? '0 : HW'(row_q);
    chn_cur = (NW'(chn_q) >= c_eff) ? '0 : NW'(chn_q);
    active  = (col_cur < w_even) && (row_cur < h_even);
    right   = col_cur[0];
    bottom  = row_cur[0];
    last    = (col_cur == w_even - CW'(1)) && (row_cur == h_even - HW'(1)) &&
              (chn_cur == c_eff - NW'(1));
  end

  // next position
  always_comb begin
    col_inc = col_cur + CW'(1);
    row_inc = row_cur;
    chn_inc = chn_cur;
    if (col_inc >= w_eff) begin
      col_inc = '0;
      row_inc = row_cur + HW'(1);
      if (row_inc >= h_eff) begin
        row_inc = '0;
        chn_inc = chn_cur + NW'(1);
        if (chn_inc >= c_eff) begin
          chn_inc = '0;
        end
      end
    end
    col_d  = accept_i ? COL_W'(col_inc) : col_q;
    row_d  = accept_i ? row_inc[mp2_pkg::ROW_W-1:0] : row_q;
    chn_d  = accept_i ? chn_inc[mp2_pkg::CHAN_W-1:0] : chn_q;
    pair_d = (accept_i && active && !right) ? sample_i : pair_q;
  end

  // top-row pair maximum, left wins ties
  always_comb begin
    pair_best.value = pair_q;
    pair_best.right = 1'b0;
    if ($signed(sample_i) > $signed(pair_q)) begin
      pair_best.value = sample_i;
      pair_best.right = 1'b1;
    end
  end

  assign wr_en_o   = accept_i && active && right && !bottom;
  assign wr_addr_o = ADDR_W'(col_cur >> 1);
  assign wr_data_o = pair_best;
  assign rd_en_o   = accept_i && active && right && bottom;
  assign rd_addr_o = ADDR_W'(col_cur >> 1);

  always_comb begin
    issue_o.valid        = rd_en_o;
    issue_o.bottom_left  = pair_q;
    issue_o.bottom_right = sample_i;
    issue_o.last         = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      chn_q  <= '0;
      pair_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      chn_q  <= chn_d;
      pair_q <= pair_d;
    end
  end

endmodule

### sv/mp2_merge.sv
// ----------------------------------------------------------------------------
// mp2_merge
// joins the stored top pair with the bottom pair and holds the result word
// ----------------------------------------------------------------------------
module mp2_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  mp2_pkg::mp2_issue_t issue_i,
  input  mp2_pkg::mp2_pair_t  top_i,
  output logic                can_take_o,
  mp2_result_if.source        result_o
);

  logic                          s1_valid_q, s1_valid_d;
  logic [mp2_pkg::SAMPLE_W-1:0]  s1_bl_q, s1_br_q;
  logic                          s1_last_q;
  logic                          out_valid_q, out_valid_d;
  logic [mp2_pkg::SAMPLE_W-1:0]  out_value_q, out_value_d;
  logic [mp2_pkg::POS_W-1:0]     out_pos_q, out_pos_d;
  logic                          out_last_q, out_last_d;
  logic                          out_load;
  logic [mp2_pkg::SAMPLE_W-1:0]  best;
  logic [mp2_pkg::POS_W-1:0]     pos;

  assign out_load   = !out_valid_q || result_o.ready;
  assign can_take_o = !s1_valid_q || out_load;

  // first maximum in scan order
  always_comb begin
    best = top_i.value;
    pos  = top_i.right ? mp2_pkg::POS_TR : mp2_pkg::POS_TL;
    if ($signed(s1_bl_q) > $signed(best)) begin
      best = s1_bl_q;
      pos  = mp2_pkg::POS_BL;
    end
    if ($signed(s1_br_q) > $signed(best)) begin
      best = s1_br_q;
      pos  = mp2_pkg::POS_BR;
    end
  end

  always_comb begin
    s1_valid_d  = accept_i ? issue_i.valid : (s1_valid_q && !out_load);
    out_valid_d = out_load ? s1_valid_q : out_valid_q;
    out_value_d = out_value_q;
    out_pos_d   = out_pos_q;
    out_last_d  = out_last_q;
    if (out_load && s1_valid_q) begin
      out_value_d = best;
      out_pos_d   = pos;
      out_last_d  = s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && issue_i.valid) begin
      s1_bl_q   <= issue_i.bottom_left;
      s1_br_q   <= issue_i.bottom_right;
      s1_last_q <= issue_i.last;
    end
    out_value_q <= out_value_d;
    out_pos_q   <= out_pos_d;
    out_last_q  <= out_last_d;
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.pooled_value  = out_value_q;
  assign result_o.max_position  = out_pos_q;
  assign result_o.last_of_frame = out_last_q;

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stream check of the 2x2 stride-2 max-pool core against its own predictor
// ----------------------------------------------------------------------------
//
// samples go in through the sample channel, register writes through the
// config channel; every accepted sample is run through a pooling predictor
// in this file, and every pooled word that comes out is checked field by
// field against the oldest prediction
// both sides idle and stall at random; one test holds the result side off
// long enough for the core to fill and stall its input
// registers are only rewritten once the core has gone quiet
//
module tb_top;

  localparam int LINE_MAX            = 1024;      // core MAX_WIDTH
  localparam int STORE_DEPTH         = LINE_MAX / 2;
  localparam int WIDE_BOTTOM_SAMPLES = 64;
  localparam int RANDOM_ITEMS        = 250;
  localparam int SETTLE_CYCLES       = 4;         // core has two pipeline stages
  localparam int HOLD_OFF_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT      = 2000;
  localparam int MAX_REPORTS         = 50;

  // register index that maps to nothing
  localparam logic [mp2_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // kinds of sample values a test draws from
  typedef enum int {VALS_ANY, VALS_CORNER, VALS_NEAR_ZERO} value_mix_e;

  // one pooled word as the core should deliver it
  typedef struct packed {
    logic signed [mp2_pkg::SAMPLE_W-1:0] value;
    logic [mp2_pkg::POS_W-1:0]           pos;
    logic                                last;
  } pooled_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mp2_sample_if smp ();
  mp2_result_if res ();
  mp2_cfg_if    cfg ();

  max_pool_2x2_stream_core #(
    .MAX_WIDTH (LINE_MAX)
  ) uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp),
    .result_o (res),
    .cfg_i    (cfg)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // pooling predictor: register copies, counters, line store, pair register
  // --------------------------------------------------------------------------
  logic [mp2_pkg::WIDTH_REG_W-1:0]     width_reg  = mp2_pkg::WIDTH_RESET;
  logic [mp2_pkg::HEIGHT_REG_W-1:0]    height_reg = mp2_pkg::HEIGHT_RESET;
  logic [mp2_pkg::CHAN_REG_W-1:0]      chan_reg   = mp2_pkg::CHAN_RESET;
  mp2_pkg::mp2_pair_t                  line_store [STORE_DEPTH];
  logic signed [mp2_pkg::SAMPLE_W-1:0] pair_left  = '0;
  int                                  col        = 0;
  int                                  row        = 0;
  int                                  chan       = 0;

  pooled_t pooled_q [$];           // pooled words still owed by the core

  int  mismatches   = 0;
  int  samples_sent = 0;
  int  quiet_cycles = 0;
  bit  tx_gaps_on   = 1'b1;
  bit  rx_stalls_on = 1'b1;
  bit  hold_off_req = 1'b0;

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // register values as the core uses them, saturated to the legal range
  function automatic void frame_bounds(output int w, output int h, output int c);
    w = clamp(int'(width_reg), 2, LINE_MAX);
    h = clamp(int'(height_reg), 2, mp2_pkg::MAX_HEIGHT);
    c = clamp(int'(chan_reg), 1, mp2_pkg::MAX_CHANNELS);
  endfunction

  // true when the next sample is the first one of a frame
  function automatic bit at_frame_start();
    int w, h, c;
    frame_bounds(w, h, c);
    return (col >= w || col == 0) && (row >= h || row == 0) && (chan >= c || chan == 0);
  endfunction

  // advance the predictor by one accepted sample word
  task automatic pool_sample(input logic signed [mp2_pkg::SAMPLE_W-1:0] s);
    int                                  w, h, c, w_even, h_even, slot;
    mp2_pkg::mp2_pair_t                  top;
    logic signed [mp2_pkg::SAMPLE_W-1:0] best;
    logic [mp2_pkg::POS_W-1:0]           pos;
    pooled_t                             word;
    frame_bounds(w, h, c);
    w_even = w & ~1;
    h_even = h & ~1;
    // a counter left beyond a bound by a register rewrite starts over
    if (col >= w) col = 0;
    if (row >= h) row = 0;
    if (chan >= c) chan = 0;
    // trailing odd column or row falls through with nothing stored
    if (col < w_even && row < h_even) begin
      slot = (col >> 1) % STORE_DEPTH;
      if (col % 2 == 0) begin
        pair_left = s;
      end else if (row % 2 == 0) begin
        // top row: keep the pair maximum, left wins a tie
        top.value = pair_left;
        top.right = 1'b0;
        if (s > pair_left) begin
          top.value = s;
          top.right = 1'b1;
        end
        line_store[slot] = top;
      end else begin
        // bottom-right sample closes the window
        top  = line_store[slot];
        best = $signed(top.value);
        pos  = top.right ? mp2_pkg::POS_TR : mp2_pkg::POS_TL;
        if (pair_left > best) begin
          best = pair_left;
          pos  = mp2_pkg::POS_BL;
        end
        if (s > best) begin
          best = s;
          pos  = mp2_pkg::POS_BR;
        end
        word.value = best;
        word.pos   = pos;
        word.last  = (col == w_even - 1) && (row == h_even - 1) && (chan == c - 1);
        pooled_q   = {pooled_q, word};
      end
    end
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) begin
        row = 0;
        chan++;
        if (chan >= c) chan = 0;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // idle length: half the time none, often short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [mp2_pkg::SAMPLE_W-1:0] pick_sample(value_mix_e mix);
    case (mix)
      VALS_ANY: return mp2_pkg::SAMPLE_W'($urandom);
      VALS_CORNER: begin
        case ($urandom_range(0, 5))
          0:       return 16'sh8000;
          1:       return 16'sh8001;
          2:       return 16'sh0000;
          3:       return 16'shFFFF;
          4:       return 16'sh7FFE;
          default: return 16'sh7FFF;
        endcase
      end
      // -2..2, so ties come up all the time
      default: return mp2_pkg::SAMPLE_W'($urandom_range(0, 4) - 2);
    endcase
  endfunction

  // offer one sample word and wait until it is taken; valid stays high so
  // the next word can follow at once
  task automatic send_sample(input logic signed [mp2_pkg::SAMPLE_W-1:0] value);
    int unsigned gap;
    gap = tx_gaps_on ? idle_len() : 0;
    if (gap != 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp.valid  <= 1'b1;
    smp.sample <= value;
    @(posedge clk_i);
    while (!smp.ready) @(posedge clk_i);
    pool_sample(value);
    samples_sent++;
  endtask

  // send until the predictor stands at the start of a frame again
  task automatic run_to_frame_end(input value_mix_e mix);
    do send_sample(pick_sample(mix));
    while (!at_frame_start());
  endtask

  // one register write word; valid stays high for a following write
  task automatic write_reg(input logic [mp2_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mp2_pkg::CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    case (idx)
      mp2_pkg::CFG_IMAGE_WIDTH:   width_reg  = value[mp2_pkg::WIDTH_REG_W-1:0];
      mp2_pkg::CFG_IMAGE_HEIGHT:  height_reg = value[mp2_pkg::HEIGHT_REG_W-1:0];
      mp2_pkg::CFG_CHANNEL_COUNT: chan_reg   = value[mp2_pkg::CHAN_REG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic close_writes();
    cfg.valid <= 1'b0;
  endtask

  // stop offering samples, wait for every owed word, then let the pipe empty
  task automatic drain();
    smp.valid <= 1'b0;
    while (pooled_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // result side: ready pattern and checker
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    forever begin
      if (hold_off_req) begin
        // long hold-off so the core backs up into its input
        hold_off_req = 1'b0;
        res.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        stall = rx_stalls_on ? idle_len() : 0;
        if (stall != 0) begin
          res.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end else begin
          res.ready <= 1'b1;
          @(posedge clk_i);
        end
      end
    end
  end

  function automatic void flag_mismatch(string field, int want, int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
  endfunction

  always @(posedge clk_i) begin
    pooled_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (pooled_q.size() == 0) begin
        mismatches++;
        $display("%0t pooled word with none expected: actual value %0d pos %0d last %0b",
                 $time, res.pooled_value, res.max_position, res.last_of_frame);
      end else begin
        want = pooled_q.pop_front();
        if (res.pooled_value !== want.value)
          flag_mismatch("pooled_value", want.value, res.pooled_value);
        if (res.max_position !== want.pos)
          flag_mismatch("max_position", want.pos, res.max_position);
        if (res.last_of_frame !== want.last)
          flag_mismatch("last_of_frame", want.last, res.last_of_frame);
      end
    end
  end

  // watchdog: cycles in a row with no word moving on any channel
  always @(posedge clk_i) begin
    if ((smp.valid && smp.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("%0t watchdog: nothing moved for %0d cycles, %0d words owed",
             $time, quiet_cycles, pooled_q.size());
    $display("FAIL max_pool_2x2_stream_core");
    $finish;
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset register values: two rows of a 32-wide map
  task automatic test_default_config();
    repeat (64) send_sample(pick_sample(VALS_ANY));
  endtask

  // 2x2 frames, one window each: max in every position, ties, extremes;
  // height 2 also lands while the row counter sits beyond it
  task automatic test_window_positions();
    logic signed [mp2_pkg::SAMPLE_W-1:0] windows [6][4] = '{
      '{16'sd5,     16'sd1,     16'sd2,     16'sd3},      // top-left
      '{16'sd1,     16'sd5,     16'sd2,     16'sd3},      // top-right
      '{16'sd1,     16'sd2,     16'sd5,     16'sd3},      // bottom-left
      '{16'sh8000,  16'sh8000,  16'sh8000,  16'sh7FFF},   // bottom-right, extremes
      '{16'sd1,     16'sd5,     16'sd2,     16'sd5},      // tie goes to first
      '{16'sh8000,  16'sh8000,  16'sh8000,  16'sh8000}    // all equal and minimal
    };
    drain();
    write_reg(mp2_pkg::CFG_IMAGE_WIDTH, 13'd2);
    write_reg(mp2_pkg::CFG_IMAGE_HEIGHT, 13'd2);
    write_reg(mp2_pkg::CFG_CHANNEL_COUNT, 13'd1);
    close_writes();
    foreach (windows[i, j]) send_sample(windows[i][j]);
  endtask

  // odd width and height drop the last column and row; 0 and 1 saturate to 2
  task automatic test_odd_sizes();
    drain();
    write_reg(mp2_pkg::CFG_IMAGE_WIDTH, 13'd3);
    write_reg(mp2_pkg::CFG_IMAGE_HEIGHT, 13'd3);
    write_reg(mp2_pkg::CFG_CHANNEL_COUNT, 13'd2);
    close_writes();
    run_to_frame_end(VALS_NEAR_ZERO);
    drain();
    write_reg(mp2_pkg::CFG_IMAGE_WIDTH, 13'd1);
    write_reg(mp2_pkg::CFG_IMAGE_HEIGHT, 13'd0);
    write_reg(mp2_pkg::CFG_CHANNEL_COUNT, 13'd0);
    close_writes();
    run_to_frame_end(VALS_NEAR_ZERO);
  endtask

  // width over range saturates to the full line; the top row fills every
  // store entry, then the start of the bottom row is pooled
  task automatic test_widest_frame();
    drain();
    write_reg(mp2_pkg::CFG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(mp2_pkg::CFG_IMAGE_HEIGHT, 13'd2);
    write_reg(mp2_pkg::CFG_CHANNEL_COUNT, 13'd1);
    close_writes();
    repeat (LINE_MAX + WIDE_BOTTOM_SAMPLES) send_sample(pick_sample(VALS_ANY));
    drain();
    // narrow the line under the running column so the frame closes early
    write_reg(mp2_pkg::CFG_IMAGE_WIDTH, 13'd2);
    close_writes();
    run_to_frame_end(VALS_ANY);
  endtask

  // shrink each register under a running counter so it starts over
  task automatic test_mid_frame_change();
    drain();
    write_reg(mp2_pkg::CFG_IMAGE_WIDTH, 13'd6);
    write_reg(mp2_pkg::CFG_IMAGE_HEIGHT, 13'd4);
    write_reg(mp2_pkg::CFG_CHANNEL_COUNT, 13'd2);
    close_writes();
    // stop in the bottom row at column 4
    repeat (22) send_sample(pick_sample(VALS_CORNER));
    drain();
    write_reg(mp2_pkg::CFG_IMAGE_WIDTH, 13'd4);
    close_writes();
    repeat (14) send_sample(pick_sample(VALS_CORNER));
    drain();
    // row 2 of channel 1: both now lie at their bound
    write_reg(mp2_pkg::CFG_IMAGE_HEIGHT, 13'd2);
    write_reg(mp2_pkg::CFG_CHANNEL_COUNT, 13'd1);
    close_writes();
    run_to_frame_end(VALS_CORNER);
  endtask

  // result side held off while samples keep coming
  task automatic test_backpressure();
    drain();
    write_reg(mp2_pkg::CFG_IMAGE_WIDTH, 13'd2);
    write_reg(mp2_pkg::CFG_IMAGE_HEIGHT, 13'd2);
    write_reg(mp2_pkg::CFG_CHANNEL_COUNT, 13'd4);
    close_writes();
    tx_gaps_on   = 1'b0;
    hold_off_req = 1'b1;
    repeat (80) send_sample(pick_sample(VALS_ANY));
    drain();
    tx_gaps_on = 1'b1;
  endtask

  // top of each register range, bits above a register's width, unused index
  task automatic test_register_extremes();
    drain();
    write_reg(mp2_pkg::CFG_IMAGE_WIDTH, 13'h1802);      // upper bits dropped, width 2
    write_reg(mp2_pkg::CFG_IMAGE_HEIGHT, 13'h1FFF);
    write_reg(mp2_pkg::CFG_CHANNEL_COUNT, 13'h1FFF);
    close_writes();
    repeat (40) send_sample(pick_sample(VALS_CORNER));
    drain();
    write_reg(mp2_pkg::CFG_IMAGE_HEIGHT, 13'h1000);
    write_reg(mp2_pkg::CFG_CHANNEL_COUNT, 13'h0400);
    write_reg(CFG_UNUSED, 13'h1FFF);
    close_writes();
    repeat (40) send_sample(pick_sample(VALS_CORNER));
    drain();
    // back to a small frame so the row counter starts over
    write_reg(mp2_pkg::CFG_IMAGE_HEIGHT, 13'd2);
    write_reg(mp2_pkg::CFG_CHANNEL_COUNT, 13'd1);
    close_writes();
  endtask

  // random small frames, mostly run to their end, some cut short
  task automatic test_random_traffic();
    int                             start;
    int unsigned                    r;
    logic [mp2_pkg::CFG_DATA_W-1:0] value;
    value_mix_e                     mix;
    start = samples_sent;
    while (samples_sent - start < RANDOM_ITEMS) begin
      drain();
      tx_gaps_on   = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      mix          = value_mix_e'($urandom_range(0, 2));
      if ($urandom_range(0, 1) == 1) begin
        r = $urandom_range(0, 19);
        if (r == 0)     value = mp2_pkg::CFG_DATA_W'($urandom_range(0, 1));
        else if (r < 4) value = mp2_pkg::CFG_DATA_W'($urandom_range(13, 48));
        else            value = mp2_pkg::CFG_DATA_W'($urandom_range(2, 12));
        value[mp2_pkg::CFG_DATA_W-1:mp2_pkg::WIDTH_REG_W] = 2'($urandom_range(0, 3));
        write_reg(mp2_pkg::CFG_IMAGE_WIDTH, value);
      end
      if ($urandom_range(0, 1) == 1) begin
        r = $urandom_range(0, 19);
        if (r == 0)     value = mp2_pkg::CFG_DATA_W'($urandom_range(0, 1));
        else if (r < 3) value = mp2_pkg::CFG_DATA_W'($urandom_range(10, 16));
        else            value = mp2_pkg::CFG_DATA_W'($urandom_range(2, 9));
        write_reg(mp2_pkg::CFG_IMAGE_HEIGHT, value);
      end
      if ($urandom_range(0, 1) == 1) begin
        value = mp2_pkg::CFG_DATA_W'($urandom_range(0, 4));
        value[mp2_pkg::CFG_DATA_W-1:mp2_pkg::CHAN_REG_W] = 2'($urandom_range(0, 3));
        write_reg(mp2_pkg::CFG_CHANNEL_COUNT, value);
      end
      if ($urandom_range(0, 15) == 0) write_reg(CFG_UNUSED, mp2_pkg::CFG_DATA_W'($urandom));
      close_writes();
      if ($urandom_range(0, 3) != 0) begin
        run_to_frame_end(mix);
        if ($urandom_range(0, 1) == 1) run_to_frame_end(mix);
      end else begin
        repeat ($urandom_range(1, 30)) send_sample(pick_sample(mix));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    smp.valid  <= 1'b0;
    smp.sample <= '0;
    cfg.valid  <= 1'b0;
    cfg.index  <= '0;
    cfg.data   <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_default_config();
    test_window_positions();
    test_odd_sizes();
    test_widest_frame();
    test_mid_frame_change();
    test_backpressure();
    test_register_extremes();
    test_random_traffic();

    drain();
    if (mismatches == 0)
      $display("PASS max_pool_2x2_stream_core");
    else
      $display("FAIL max_pool_2x2_stream_core");
    $finish;
  end

endmodule

### sim.f
sv/mp2_pkg.sv
sv/mp2_sample_if.sv
sv/mp2_result_if.sv
sv/mp2_cfg_if.sv
sv/mp2_ram.sv
sv/mp2_scan.sv
sv/mp2_merge.sv
sv/max_pool_2x2_stream_core.sv
tb/tb_top.sv
